[hw/rtl/mdf_pkg.sv]
// constants and types shared by the prime-field division pipeline
package mdf_pkg;

	localparam int unsigned FW = 30;
	localparam logic [FW-1:0] PRIME = 30'd998244353;
	localparam logic [FW-1:0] EXPONENT = 30'd998244351;
	localparam int unsigned NCELLS = FW;
	localparam int unsigned CELL_LAT = 4;
	// barrett constant floor(2^60 / prime), fits in 31 bits
	localparam logic [63:0] MU_WIDE = (64'd1 << 60) / 64'd998244353;
	localparam logic [30:0] MU = MU_WIDE[30:0];
	localparam logic [31:0] PRIME_X1 = {2'b00, PRIME};
	localparam logic [31:0] PRIME_X2 = {1'b0, PRIME, 1'b0};

	typedef logic [FW-1:0] elem_t;

endpackage

[hw/rtl/modular_division_fermat_core.sv]
// prime-field division p / q mod 998244353 by a pipelined square-and-multiply chain
//
// usage:
//   s_tvalid/s_tready/s_tdata take one transaction per cycle, each a
//   numerator and denominator; m_tvalid/m_tready/m_tdata return one
//   quotient per input transaction, in order.
//   operands at or above the prime are reduced first; a zero denominator
//   gives a zero quotient.
// pipeline: from input transaction to m_tvalid, one reduce stage,
//   30 cells of 4 stages each, one output register.
// throughput: one transaction per cycle; set by the chain of 30 cells, one
//   per exponent bit, each holding two four-stage barrett multipliers.
// stall: when the output register is full and m_tready is low, the whole
//   chain holds and s_tready drops; no data is lost.
// reset: arst_n clears all valid bits; items in flight are dropped.
module modular_division_fermat_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // numerator[29:0], denominator[59:30], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // quotient[29:0], zero pad
);

	logic ce;
	logic in_valid_s1;
	mdf_pkg::elem_t acc_s1;
	mdf_pkg::elem_t base_s1;
	logic valid_c [mdf_pkg::NCELLS+1];
	mdf_pkg::elem_t acc_c [mdf_pkg::NCELLS+1];
	mdf_pkg::elem_t base_c [mdf_pkg::NCELLS+1];
	logic out_valid_q;
	mdf_pkg::elem_t out_data_q;

	assign ce = !out_valid_q || m_tready;
	assign s_tready = ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (ce) begin
			in_valid_s1 <= s_tvalid;
			out_valid_q <= valid_c[mdf_pkg::NCELLS];
		end
	end

	// inputs are below twice the prime, one subtract reduces them
	always_ff @(posedge clk) begin
		if (ce) begin
			acc_s1 <= (s_tdata[29:0] >= mdf_pkg::PRIME) ?
				s_tdata[29:0] - mdf_pkg::PRIME : s_tdata[29:0];
			base_s1 <= (s_tdata[59:30] >= mdf_pkg::PRIME) ?
				s_tdata[59:30] - mdf_pkg::PRIME : s_tdata[59:30];
			out_data_q <= acc_c[mdf_pkg::NCELLS];
		end
	end

	assign valid_c[0] = in_valid_s1;
	assign acc_c[0]   = acc_s1;
	assign base_c[0]  = base_s1;

	for (genvar i = 0; i < mdf_pkg::NCELLS; i++) begin : g_cell
		mdf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ce       (ce),
			.mul_en   (mdf_pkg::EXPONENT[i]),
			.in_valid (valid_c[i]),
			.in_acc   (acc_c[i]),
			.in_base  (base_c[i]),
			.out_valid(valid_c[i+1]),
			.out_acc  (acc_c[i+1]),
			.out_base (base_c[i+1])
		);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_data_q};

endmodule

[hw/rtl/mdf_mulmod.sv]
// four-stage barrett modular multiplier for the fixed prime
module mdf_mulmod (
	input  logic                clk,
	input  logic                ce,
	input  mdf_pkg::elem_t      a,
	input  mdf_pkg::elem_t      b,
	output mdf_pkg::elem_t      y
);

	logic [59:0] t_s1;
	logic [61:0] q2_s2;
	logic [31:0] t_s2;
	logic [31:0] r_s3;
	mdf_pkg::elem_t y_s4;
	logic [60:0] qp;

	assign qp = q2_s2[61:31] * mdf_pkg::PRIME;

	always_ff @(posedge clk) begin
		if (ce) begin
			t_s1  <= a * b;
			q2_s2 <= t_s1[59:29] * mdf_pkg::MU;
			t_s2  <= t_s1[31:0];
			// remainder is below three times the prime
			r_s3  <= t_s2 - qp[31:0];
			if (r_s3 >= mdf_pkg::PRIME_X2) begin
				y_s4 <= 30'(r_s3 - mdf_pkg::PRIME_X2);
			end else if (r_s3 >= mdf_pkg::PRIME_X1) begin
				y_s4 <= 30'(r_s3 - mdf_pkg::PRIME_X1);
			end else begin
				y_s4 <= r_s3[29:0];
			end
		end
	end

	assign y = y_s4;

endmodule

[hw/rtl/mdf_cell.sv]
// one exponent bit: square the base, multiply the accumulator when the bit is set
module mdf_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ce,
	input  logic                mul_en,
	input  logic                in_valid,
	input  mdf_pkg::elem_t      in_acc,
	input  mdf_pkg::elem_t      in_base,
	output logic                out_valid,
	output mdf_pkg::elem_t      out_acc,
	output mdf_pkg::elem_t      out_base
);

	logic [mdf_pkg::CELL_LAT-1:0] valid_q;
	mdf_pkg::elem_t acc_q [mdf_pkg::CELL_LAT];
	mdf_pkg::elem_t prod;

	mdf_mulmod u_sq (.clk(clk), .ce(ce), .a(in_base), .b(in_base), .y(out_base));
	mdf_mulmod u_mul (.clk(clk), .ce(ce), .a(in_acc), .b(in_base), .y(prod));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ce) begin
			valid_q <= {valid_q[mdf_pkg::CELL_LAT-2:0], in_valid};
		end
	end

	// accumulator delay line for cells whose exponent bit is clear
	always_ff @(posedge clk) begin
		if (ce) begin
			acc_q[0] <= in_acc;
			for (int i = 1; i < mdf_pkg::CELL_LAT; i++) begin
				acc_q[i] <= acc_q[i-1];
			end
		end
	end

	assign out_valid = valid_q[mdf_pkg::CELL_LAT-1];
	assign out_acc   = mul_en ? prod : acc_q[mdf_pkg::CELL_LAT-1];

endmodule
